### hw/rtl/gf2pa_pkg.sv
`default_nettype none
package gf2pa_pkg;

  // operand width in use, and the width of the working row
  localparam int POLY_BITS = 32;
  localparam int IN_W      = 32;
  localparam int WORD      = 64;
  localparam int CNT_W     = 7;

  localparam logic [2:0] CMD_MUL = 3'd0;
  localparam logic [2:0] CMD_QUO = 3'd1;
  localparam logic [2:0] CMD_REM = 3'd2;
  localparam logic [2:0] CMD_GCD = 3'd3;
  localparam logic [2:0] CMD_LCM = 3'd4;

  typedef enum logic [2:0] {
    X_HOLD,
    X_LOAD,
    X_SHL,
    X_SHR,
    X_XOR,
    X_FROM_Y
  } x_op_t;

  typedef enum logic [1:0] {
    Y_HOLD,
    Y_LOAD,
    Y_SHL,
    Y_FROM_X
  } y_op_t;

  typedef enum logic [1:0] {
    P_HOLD,
    P_CLR,
    P_MAC
  } p_op_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    x_op_t x_op;
    logic  x_sel;
    y_op_t y_op;
    p_op_t p_op;
    logic  p_add;
  } cell_ctl_t;

  // keep only the low POLY_BITS coefficients
  function automatic logic [IN_W-1:0] mask_operand(input logic [IN_W-1:0] v);
    logic [IN_W-1:0] m;
    for (int i = 0; i < IN_W; i++) begin
      m[i] = (i < POLY_BITS) ? v[i] : 1'b0;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/gf2pa_cell.sv
`default_nettype none
module gf2pa_cell (
  input  wire logic                 clk,
  input  wire gf2pa_pkg::cell_ctl_t ctl,
  input  wire logic                 ld_x,
  input  wire logic                 ld_y,
  input  wire logic                 x_lo,
  input  wire logic                 x_hi,
  input  wire logic                 y_lo,
  input  wire logic                 p_lo,
  output logic                      x,
  output logic                      y,
  output logic                      p
);

  logic x_r, x_nxt;
  logic y_r, y_nxt;
  logic p_r, p_nxt;

  always_comb begin
    case (ctl.x_op)
      gf2pa_pkg::X_HOLD:   x_nxt = x_r;
      gf2pa_pkg::X_LOAD:   x_nxt = ld_x;
      gf2pa_pkg::X_SHL:    x_nxt = x_lo ^ (ctl.x_sel & y_lo);
      gf2pa_pkg::X_SHR:    x_nxt = x_hi;
      gf2pa_pkg::X_XOR:    x_nxt = x_r ^ y_r;
      gf2pa_pkg::X_FROM_Y: x_nxt = y_r;
      default:             x_nxt = x_r;
    endcase
  end

  always_comb begin
    case (ctl.y_op)
      gf2pa_pkg::Y_HOLD:   y_nxt = y_r;
      gf2pa_pkg::Y_LOAD:   y_nxt = ld_y;
      gf2pa_pkg::Y_SHL:    y_nxt = y_lo;
      gf2pa_pkg::Y_FROM_X: y_nxt = x_r;
      default:             y_nxt = y_r;
    endcase
  end

  // p accumulates shifted partial products or quotient bits
  always_comb begin
    case (ctl.p_op)
      gf2pa_pkg::P_HOLD: p_nxt = p_r;
      gf2pa_pkg::P_CLR:  p_nxt = 1'b0;
      gf2pa_pkg::P_MAC:  p_nxt = p_lo ^ (ctl.p_add & x_r);
      default:           p_nxt = p_r;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    p_r <= p_nxt;
  end

  assign x = x_r;
  assign y = y_r;
  assign p = p_r;

endmodule
`default_nettype wire

### hw/rtl/gf2_polynomial_arithmetic_unit.sv
// GF(2) polynomial arithmetic unit: multiply, quotient, remainder, gcd, lcm.
// Input channel (in_valid/in_ready) carries a command and two operands, bit i
// holding the coefficient of x^i. Each transfer yields exactly one result
// transfer on the output channel (out_valid/out_ready): result polynomial,
// coefficient count (1 for the zero polynomial) and a divide-by-zero flag.
// The work is done by a row of 64 bit cells sharing a broadcast control word;
// in a shift step each cell takes its neighbor's bit, so every step moves
// operands by one coefficient position. The commands run these steps:
//   multiply    shift-and-add over the coefficients of the second operand
//   quotient    normalize, then divide
//   remainder   as quotient, then a right shift
//   gcd         normalize, reduce/align, then a right shift
//   lcm         multiply, then gcd, then a 64-bit division by the gcd
// with an entry step before and a final size scan and hand-off after.
// One item is worked at a time; in_ready is high only while the
// row is free. A finished result sits in the output register, so a new item
// can be taken while the receiver stalls; a second result waits in the row
// until the output register frees up. Reset (rst_n low, synchronous) empties
// the output register and returns the sequencer to idle.
`default_nettype none
module gf2_polynomial_arithmetic_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [31:0] in_first_poly,
  input  wire logic [31:0] in_second_poly,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_poly,
  output logic [6:0]       out_result_size,
  output logic             out_divide_by_zero
);

  localparam int W  = gf2pa_pkg::WORD;
  localparam int IW = gf2pa_pkg::IN_W;
  localparam int CW = gf2pa_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_NORM  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_GCD   = 8'b0010_0000,
    S_SHR   = 8'b0100_0000,
    S_SIZE  = 8'b1000_0000
  } state_t;

  // where a finished result comes from
  typedef enum logic [1:0] {
    F_X,
    F_P,
    F_ZERO
  } fin_src_t;

  state_t             state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [IW-1:0]      a_r, a_nxt;
  logic [IW-1:0]      b_r, b_nxt;
  logic [CW-1:0]      tx_r, tx_nxt;   // coefficient positions left in x
  logic [CW-1:0]      ty_r, ty_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               phase_r, phase_nxt;  // lcm: gcd done, dividing
  logic               dz_r, dz_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [W-1:0]       out_poly_r, out_poly_nxt;
  logic [CW-1:0]      out_size_r, out_size_nxt;
  logic               out_dz_r, out_dz_nxt;

  gf2pa_pkg::cell_ctl_t ctl;
  logic [W-1:0]       ld_x, ld_y;
  logic [W-1:0]       x_q, y_q, p_q;
  logic               p_in;
  logic               fin;
  fin_src_t           fin_src;
  logic               x_done, y_done, q_bit;

  // the cell row, each cell wired to its neighbors
  for (genvar i = 0; i < W; i++) begin : g_cell
    gf2pa_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .ld_x (ld_x[i]),
      .ld_y (ld_y[i]),
      .x_lo ((i == 0) ? 1'b0 : x_q[(i == 0) ? 0 : i-1]),
      .x_hi ((i == W-1) ? 1'b0 : x_q[(i == W-1) ? W-1 : i+1]),
      .y_lo ((i == 0) ? 1'b0 : y_q[(i == 0) ? 0 : i-1]),
      .p_lo ((i == 0) ? p_in : p_q[(i == 0) ? 0 : i-1]),
      .x    (x_q[i]),
      .y    (y_q[i]),
      .p    (p_q[i])
    );
  end

  assign in_ready = (state_r == S_IDLE);
  assign x_done   = x_q[W-1] | (tx_r == '0);
  assign y_done   = y_q[W-1] | (ty_r == '0);
  assign q_bit    = x_q[W-1];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_poly_nxt  = out_poly_r;
    out_size_nxt  = out_size_r;
    out_dz_nxt    = out_dz_r;
    ctl.x_op      = gf2pa_pkg::X_HOLD;
    ctl.x_sel     = 1'b0;
    ctl.y_op      = gf2pa_pkg::Y_HOLD;
    ctl.p_op      = gf2pa_pkg::P_HOLD;
    ctl.p_add     = 1'b0;
    ld_x          = '0;
    ld_y          = '0;
    p_in          = 1'b0;
    fin           = 1'b0;
    fin_src       = F_ZERO;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          a_nxt     = gf2pa_pkg::mask_operand(in_first_poly);
          b_nxt     = gf2pa_pkg::mask_operand(in_second_poly);
          phase_nxt = 1'b0;
          dz_nxt    = 1'b0;
          state_nxt = S_START;
        end
      end

      S_START: begin
        case (cmd_r)
          gf2pa_pkg::CMD_MUL, gf2pa_pkg::CMD_LCM: begin
            if (cmd_r == gf2pa_pkg::CMD_LCM && (a_r == '0 || b_r == '0)) begin
              fin = 1'b1;
            end else begin
              // b sits at the top so its high coefficient leaves first
              ld_x      = {{(W-IW){1'b0}}, a_r};
              ld_y      = {b_r, {(W-IW){1'b0}}};
              ctl.x_op  = gf2pa_pkg::X_LOAD;
              ctl.y_op  = gf2pa_pkg::Y_LOAD;
              ctl.p_op  = gf2pa_pkg::P_CLR;
              cnt_nxt   = CW'(IW);
              state_nxt = S_MUL;
            end
          end
          gf2pa_pkg::CMD_QUO, gf2pa_pkg::CMD_REM, gf2pa_pkg::CMD_GCD: begin
            if (cmd_r != gf2pa_pkg::CMD_GCD && b_r == '0) begin
              dz_nxt = 1'b1;
              fin    = 1'b1;
            end else begin
              ld_x      = {{(W-IW){1'b0}}, a_r};
              ld_y      = {{(W-IW){1'b0}}, b_r};
              ctl.x_op  = gf2pa_pkg::X_LOAD;
              ctl.y_op  = gf2pa_pkg::Y_LOAD;
              ctl.p_op  = gf2pa_pkg::P_CLR;
              tx_nxt    = FULL;
              ty_nxt    = FULL;
              state_nxt = S_NORM;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_MUL: begin
        if (cnt_r == '0) begin
          if (cmd_r == gf2pa_pkg::CMD_MUL) begin
            fin     = 1'b1;
            fin_src = F_P;
          end else begin
            // lcm: product kept in p, now the gcd of the operands
            ld_x      = {{(W-IW){1'b0}}, a_r};
            ld_y      = {{(W-IW){1'b0}}, b_r};
            ctl.x_op  = gf2pa_pkg::X_LOAD;
            ctl.y_op  = gf2pa_pkg::Y_LOAD;
            tx_nxt    = FULL;
            ty_nxt    = FULL;
            state_nxt = S_NORM;
          end
        end else begin
          ctl.p_op  = gf2pa_pkg::P_MAC;
          ctl.p_add = y_q[W-1];
          ctl.y_op  = gf2pa_pkg::Y_SHL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end

      S_NORM: begin
        // left-align both operands so their top coefficients sit at the msb
        if (!x_done) begin
          ctl.x_op = gf2pa_pkg::X_SHL;
          tx_nxt   = tx_r - 1'b1;
        end
        if (!y_done) begin
          ctl.y_op = gf2pa_pkg::Y_SHL;
          ty_nxt   = ty_r - 1'b1;
        end
        if (x_done && y_done) begin
          if (cmd_r == gf2pa_pkg::CMD_GCD || (cmd_r == gf2pa_pkg::CMD_LCM && !phase_r)) begin
            state_nxt = S_GCD;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (tx_r < ty_r) begin
          if (cmd_r == gf2pa_pkg::CMD_REM) begin
            cnt_nxt   = FULL - tx_r;
            state_nxt = S_SHR;
          end else begin
            fin     = 1'b1;
            fin_src = F_P;
          end
        end else begin
          // one long-division step: cancel the top, shift, record quotient bit
          ctl.x_op  = gf2pa_pkg::X_SHL;
          ctl.x_sel = q_bit;
          ctl.p_op  = gf2pa_pkg::P_MAC;
          p_in      = q_bit;
          tx_nxt    = tx_r - 1'b1;
        end
      end

      S_GCD: begin
        if (ty_r == '0) begin
          if (cmd_r == gf2pa_pkg::CMD_GCD) begin
            cnt_nxt   = FULL - tx_r;
            state_nxt = S_SHR;
          end else begin
            // lcm: aligned gcd becomes the divisor, product the dividend
            ctl.y_op  = gf2pa_pkg::Y_FROM_X;
            ctl.x_op  = gf2pa_pkg::X_LOAD;
            ld_x      = p_q;
            ctl.p_op  = gf2pa_pkg::P_CLR;
            ty_nxt    = tx_r;
            tx_nxt    = FULL;
            phase_nxt = 1'b1;
            state_nxt = S_NORM;
          end
        end else if (!x_done) begin
          ctl.x_op = gf2pa_pkg::X_SHL;
          tx_nxt   = tx_r - 1'b1;
        end else if (tx_r < ty_r) begin
          ctl.x_op = gf2pa_pkg::X_FROM_Y;
          ctl.y_op = gf2pa_pkg::Y_FROM_X;
          tx_nxt   = ty_r;
          ty_nxt   = tx_r;
        end else begin
          // aligned tops cancel: a ^= b * x^(da-db)
          ctl.x_op = gf2pa_pkg::X_XOR;
        end
      end

      S_SHR: begin
        if (cnt_r == '0) begin
          fin     = 1'b1;
          fin_src = F_X;
        end else begin
          ctl.x_op = gf2pa_pkg::X_SHR;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end

      S_SIZE: begin
        // y keeps the result, x is shifted up to find its degree
        if (!x_done) begin
          ctl.x_op = gf2pa_pkg::X_SHL;
          tx_nxt   = tx_r - 1'b1;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_poly_nxt  = y_q;
          out_size_nxt  = (tx_r == '0) ? CW'(1) : tx_r;
          out_dz_nxt    = dz_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      case (fin_src)
        F_X: begin
          ld_x   = x_q;
          ld_y   = x_q;
          tx_nxt = FULL;
        end
        F_P: begin
          ld_x   = p_q;
          ld_y   = p_q;
          tx_nxt = FULL;
        end
        default: begin
          ld_x   = '0;
          ld_y   = '0;
          tx_nxt = '0;
        end
      endcase
      ctl.x_op  = gf2pa_pkg::X_LOAD;
      ctl.y_op  = gf2pa_pkg::Y_LOAD;
      ctl.p_op  = gf2pa_pkg::P_HOLD;
      state_nxt = S_SIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    cnt_r      <= cnt_nxt;
    dz_r       <= dz_nxt;
    out_poly_r <= out_poly_nxt;
    out_size_r <= out_size_nxt;
    out_dz_r   <= out_dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_poly    = out_poly_r;
  assign out_result_size    = out_size_r;
  assign out_divide_by_zero = out_dz_r;

endmodule
`default_nettype wire
